/* src/rpn_pkg.sv */
// Shared types and constants for the reverse Polish stack evaluator.
// No dependencies; imported by rpn_divider, rpn_stack_evaluator_unit and the testbench.
`default_nettype none

package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_STACK_DEPTH = 32;
  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 32;
  localparam int OUT_TUSER_W     = 1;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_OPER = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_END
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/rpn_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for the request and response structs.
`default_nettype none

module rpn_divider (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t     rsp_o
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              negq_q, negq_d;
  logic              negr_q, negr_d;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              sign_a, sign_b;

  assign sign_a  = req_i.dividend[DATA_W-1];
  assign sign_b  = req_i.divisor[DATA_W-1];
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    negq_d = negq_q;
    negr_d = negr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_W - 1);
      rem_d  = '0;
      quo_d  = sign_a ? (~req_i.dividend + DATA_W'(1)) : req_i.dividend;
      dvs_d  = sign_b ? (~req_i.divisor + DATA_W'(1)) : req_i.divisor;
      negq_d = sign_a ^ sign_b;
      negr_d = sign_a;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = negq_q ? (~quo_q + DATA_W'(1)) : quo_q;
  assign rsp_o.remainder = negr_q ? (~rem_q + DATA_W'(1)) : rem_q;

endmodule

`default_nettype wire

/* src/rpn_stack_evaluator_unit.sv */
// Top level of the reverse Polish stack evaluator: sequencer, operand stack memory
// and output register. Depends on rpn_pkg and rpn_divider.
//
//   channel  | dir | tdata                                   | tuser
//   s_axis   | in  | [31:0] number_value, [34:32] operator   | [1:0] kind
//   m_axis   | out | [31:0] result_value                     | [0] error_flag
//
// Push writes the stack directly from idle; add, subtract and multiply pass through S_OPER (stack read, write back).
// Divide and remainder pass through S_OPER and S_DIV, where the bit-serial divider runs 32 steps.
// End passes through S_END and holds there while the previous result beat is not taken.
// The stack memory needs no clearing pass after reset; only the count is reset.
// s_axis_tready is low while an operator, divide or end is in progress.
`default_nettype none

module rpn_stack_evaluator_unit #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] number_value, [34:32] operator_code, [39:35] zero
  input  wire logic [rpn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  wire logic [rpn_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [31:0] result_value
  output logic [rpn_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // [0] error_flag
  output logic [rpn_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              err_q, err_d;
  op_e               op_q, op_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_err_q, out_err_d;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [AW-1:0]     raddr_a, raddr_b;

  logic [DATA_W-1:0] in_value;
  logic [2:0]        in_code;
  kind_e             in_kind;
  logic              in_fire;
  logic [DATA_W-1:0] product;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_value = s_axis_tdata[DATA_W-1:0];
  assign in_code  = s_axis_tdata[DATA_W+2:DATA_W];
  assign in_kind  = kind_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign cnt_m1  = count_q - CW'(1);
  assign cnt_m2  = count_q - CW'(2);
  assign raddr_a = cnt_m1[AW-1:0];
  assign raddr_b = cnt_m2[AW-1:0];
  assign product = rd_b_q * rd_a_q;

  rpn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    err_d            = err_q;
    op_d             = op_q;
    out_valid_d      = out_valid_q && !m_axis_tready;
    out_data_d       = out_data_q;
    out_err_d        = out_err_q;
    mem_we           = 1'b0;
    mem_waddr        = raddr_b;
    mem_wdata        = rd_b_q + rd_a_q;
    div_req.start    = 1'b0;
    div_req.dividend = rd_b_q;
    div_req.divisor  = rd_a_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_PUSH: begin
              if (!err_q) begin
                if (count_q == CW'(STACK_DEPTH)) begin
                  err_d = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = count_q[AW-1:0];
                  mem_wdata = in_value;
                  count_d   = count_q + CW'(1);
                end
              end
            end
            KIND_OPER: begin
              if (!err_q) begin
                if (count_q < CW'(2) || in_code > OP_REM) begin
                  err_d = 1'b1;
                end else begin
                  op_d    = op_e'(in_code);
                  state_d = S_OPER;
                end
              end
            end
            KIND_END: begin
              state_d = S_END;
            end
            default: begin
            end
          endcase
        end
      end
      S_OPER: begin
        state_d = S_IDLE;
        case (op_q)
          OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = rd_b_q + rd_a_q;
            count_d   = cnt_m1;
          end
          OP_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = rd_b_q - rd_a_q;
            count_d   = cnt_m1;
          end
          OP_MUL: begin
            mem_we    = 1'b1;
            mem_wdata = product;
            count_d   = cnt_m1;
          end
          OP_DIV, OP_REM: begin
            if (rd_a_q == '0) begin
              err_d = 1'b1;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = (op_q == OP_REM) ? div_rsp.remainder : div_rsp.quotient;
          count_d   = cnt_m1;
          state_d   = S_IDLE;
        end
      end
      S_END: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (!err_q && count_q == CW'(1)) begin
            out_data_d = rd_a_q;
            out_err_d  = 1'b0;
          end else begin
            out_data_d = '0;
            out_err_d  = 1'b1;
          end
          count_d = '0;
          err_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

/* test/tb_rpn_stack_evaluator_unit.sv */
// Testbench for rpn_stack_evaluator_unit: directed token table, then random expressions,
// every result beat checked against the table's expected value or an in-bench stack predictor.
// Depends on rpn_pkg and the evaluator RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_unit;
  import rpn_pkg::*;

  localparam int          STACK_DEPTH   = DEF_STACK_DEPTH;
  localparam int          RANDOM_ITEMS  = 1850;
  localparam int          DRAIN_CYCLES  = 60;
  localparam logic [1:0]  KIND_BAD      = 2'd3;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam logic [31:0] INT_MIN       = 32'h8000_0000;
  localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  op;
  } token_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } eval_t;

  typedef struct {
    token_t tok;
    bit     typed;
    eval_t  want;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  rpn_stack_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  logic [31:0] rpn_stack [STACK_DEPTH];
  int          rpn_depth = 0;
  bit          rpn_fault = 1'b0;
  eval_t       pending_evals[$];
  row_t        directed_rows[$];
  token_t      expr_q[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          ready_left = 0;

  function automatic eval_t evaluate_token(token_t t, output bit emits);
    logic [31:0] lhs, rhs, res;
    longint      sl, sr, q;
    bit          ok;
    eval_t       r;
    emits = 1'b0;
    r = '0;
    case (t.kind)
      KIND_PUSH: if (!rpn_fault) begin
        if (rpn_depth >= STACK_DEPTH) begin
          rpn_fault = 1'b1;
        end else begin
          rpn_stack[rpn_depth] = t.value;
          rpn_depth++;
        end
      end
      KIND_OPER: if (!rpn_fault) begin
        if (rpn_depth < 2) begin
          rpn_fault = 1'b1;
        end else begin
          rhs = rpn_stack[rpn_depth-1];
          lhs = rpn_stack[rpn_depth-2];
          sl  = $signed(lhs);
          sr  = $signed(rhs);
          ok  = 1'b1;
          res = '0;
          case (t.op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            OP_DIV, OP_REM: begin
              if (rhs == '0) begin
                ok = 1'b0;
              end else begin
                q = (t.op == OP_DIV) ? sl / sr : sl % sr;
                res = q[31:0];
              end
            end
            default: ok = 1'b0;
          endcase
          if (ok) begin
            rpn_stack[rpn_depth-2] = res;
            rpn_depth--;
          end else begin
            rpn_fault = 1'b1;
          end
        end
      end
      KIND_END: begin
        emits = 1'b1;
        if (!rpn_fault && rpn_depth == 1) begin
          r.value = rpn_stack[0];
          r.err   = 1'b0;
        end else begin
          r.value = '0;
          r.err   = 1'b1;
        end
        rpn_depth = 0;
        rpn_fault = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_token(token_t t, bit typed, eval_t want);
    int    gap;
    bit    emits;
    eval_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, t.op, t.value};
    s_axis_tuser  <= t.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = evaluate_token(t, emits);
    if (emits) pending_evals.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic add_row(logic [1:0] kind, logic [31:0] value, logic [2:0] op,
                         bit typed = 1'b0, logic [31:0] want_value = '0,
                         logic want_err = 1'b0);
    row_t r;
    r.tok.kind   = kind;
    r.tok.value  = value;
    r.tok.op     = op;
    r.typed      = typed;
    r.want.value = want_value;
    r.want.err   = want_err;
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return '0;
      3:       return MINUS_ONE;
      4, 5, 6: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic token_t make_token(logic [1:0] kind, logic [31:0] value, logic [2:0] op);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.op    = op;
    return t;
  endfunction

  task automatic build_well_formed();
    int target, pushed, depth;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(2, STACK_DEPTH)
                                         : $urandom_range(1, 5);
    pushed = 0;
    depth  = 0;
    while (pushed < target || depth > 1) begin
      if ($urandom_range(0, 39) == 0)
        expr_q.push_back(make_token(KIND_BAD, $urandom, 3'($urandom_range(0, 7))));
      if (pushed < target && (depth < 2 || $urandom_range(0, 1))) begin
        expr_q.push_back(make_token(KIND_PUSH, pick_number(), 3'($urandom_range(0, 7))));
        pushed++;
        depth++;
      end else begin
        expr_q.push_back(make_token(KIND_OPER, $urandom,
          3'(($urandom_range(0, 39) == 0) ? $urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)
                                          : $urandom_range(OP_ADD, OP_REM))));
        depth--;
      end
    end
  endtask

  task automatic build_fill(int extra);
    repeat (STACK_DEPTH + extra)
      expr_q.push_back(make_token(KIND_PUSH, pick_number(), 3'($urandom_range(0, 7))));
    repeat (STACK_DEPTH - 1)
      expr_q.push_back(make_token(KIND_OPER, $urandom, 3'($urandom_range(OP_ADD, OP_MUL))));
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 10))
      expr_q.push_back(make_token(2'($urandom_range(0, 3)), pick_number(),
                                  3'($urandom_range(0, 7))));
  endtask

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(50, 400);
    end
    ready_left--;
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    eval_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_evals.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h err %b", m_axis_tdata,
                                  m_axis_tuser[0]));
      end else begin
        exp_r = pending_evals.pop_front();
        if (m_axis_tdata !== exp_r.value)
          report_mismatch($sformatf("result_value got %h want %h", m_axis_tdata,
                                    exp_r.value));
        if (m_axis_tuser[0] !== exp_r.err)
          report_mismatch($sformatf("error_flag got %b want %b", m_axis_tuser[0],
                                    exp_r.err));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("rpn_stack_evaluator_unit verification failed");
    $finish;
  end

  initial begin
    int    counted, expr_idx, style;
    eval_t none;
    none = '0;

    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b1);
    add_row(KIND_PUSH, INT_MIN,   OP_ADD);
    add_row(KIND_PUSH, MINUS_ONE, OP_ADD);
    add_row(KIND_OPER, '0,        OP_DIV);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, INT_MIN, 1'b0);
    add_row(KIND_PUSH, INT_MIN,   OP_ADD);
    add_row(KIND_PUSH, MINUS_ONE, OP_ADD);
    add_row(KIND_OPER, '0,        OP_REM);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b0);
    add_row(KIND_PUSH, INT_MAX,   OP_ADD);
    add_row(KIND_PUSH, -32'sd7,   OP_ADD);
    add_row(KIND_OPER, '0,        OP_REM);
    add_row(KIND_PUSH, 32'd3,     OP_ADD);
    add_row(KIND_OPER, '0,        OP_MUL);
    add_row(KIND_PUSH, 32'd5,     OP_ADD);
    add_row(KIND_OPER, '0,        OP_SUB);
    add_row(KIND_PUSH, 32'd2,     OP_ADD);
    add_row(KIND_OPER, MINUS_ONE, OP_ADD);
    add_row(KIND_END,  '0,        OP_ADD);
    add_row(KIND_PUSH, 32'd4,     OP_ADD);
    add_row(KIND_PUSH, '0,        OP_ADD);
    add_row(KIND_OPER, '0,        OP_DIV);
    add_row(KIND_PUSH, 32'd1,     OP_ADD);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b1);
    add_row(KIND_OPER, '0,        OP_SUB);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b1);
    add_row(KIND_PUSH, 32'd1,     OP_ADD);
    add_row(KIND_BAD,  MINUS_ONE, OP_RSVD_LAST);
    add_row(KIND_PUSH, 32'd2,     OP_ADD);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b1);
    add_row(KIND_PUSH, 32'd3,     OP_ADD);
    add_row(KIND_OPER, '0,        OP_RSVD_FIRST);
    add_row(KIND_END,  '0,        OP_ADD, 1'b1, '0, 1'b1);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_token(directed_rows[i].tok, directed_rows[i].typed, directed_rows[i].want);

    counted  = 0;
    expr_idx = 0;
    while (counted < RANDOM_ITEMS) begin
      expr_q.delete();
      style = $urandom_range(0, 99);
      if (expr_idx == 0)       build_fill(1);
      else if (expr_idx == 1)  build_fill(0);
      else if (style < 70)     build_well_formed();
      else if (style < 76)     build_fill($urandom_range(0, 1));
      else                     build_noise();
      expr_q.push_back(make_token(KIND_END, $urandom, 3'($urandom_range(0, 7))));
      foreach (expr_q[i]) begin
        send_token(expr_q[i], 1'b0, none);
        if (expr_q[i].kind != KIND_BAD) counted++;
      end
      expr_idx++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_evals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_evals.size() == 0) begin
      $display("rpn_stack_evaluator_unit verification clean");
    end else begin
      $display("rpn_stack_evaluator_unit verification failed");
    end
    $finish;
  end

endmodule
